/* src/dmarf_pkg.sv */
// ----------------------------------------------------------------------------
// DMA register file package
// Shared constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package dmarf_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  localparam logic [31:0] REG_DPCR   = 32'h1f80_10f0;
  localparam logic [31:0] REG_DICR   = 32'h1f80_10f4;
  localparam logic [31:0] REG_SPARE0 = 32'h1f80_10f8;
  localparam logic [31:0] REG_SPARE1 = 32'h1f80_10fc;
  localparam logic [31:0] DEC_MASK   = 32'h1fff_ff8f;
  localparam logic [31:0] REG_MADR   = 32'h1f80_1080;
  localparam logic [31:0] REG_BCR    = 32'h1f80_1084;
  localparam logic [31:0] REG_CHCR   = 32'h1f80_1088;
  localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [31:0] CHCR_BITS  = 32'h7177_0703;
  localparam logic [31:0] LAST_KEEP  = 32'h5100_0000;
  localparam logic [31:0] LAST_FORCE = 32'h0000_0002;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic capture;   // load the input transfer
    logic execute;   // perform the access and load the result
  } cmd_t;

endpackage

/* src/dmarf_ctrl.sv */
// ----------------------------------------------------------------------------
// DMA register file controller
// Sequences capture, execute and result hand-off.
// ----------------------------------------------------------------------------
module dmarf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output dmarf_pkg::cmd_t cmd
);
  import dmarf_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (!out_stall) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: cmd.execute = 1'b1;
      ST_HOLD: begin
        out_valid   = 1'b1;
        in_stall    = out_stall;
        cmd.capture = in_valid && !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  a_exec_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute) else $error("capture not followed by execute");
  a_exec_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid) else $error("result not presented");
  a_no_cap_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute)) else $error("capture during execute");

endmodule

/* src/dmarf_dp.sv */
// ----------------------------------------------------------------------------
// DMA register file datapath
// Register state, address decode, read mux and write update.
// ----------------------------------------------------------------------------
module dmarf_dp #(
  parameter int NUM_CHANNELS = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dmarf_pkg::cmd_t cmd,
  input  logic [1:0]      in_operation,
  input  logic [31:0]     in_address,
  input  logic [1:0]      in_access_size,
  input  logic [31:0]     in_write_data,
  input  logic [2:0]      in_done_channel,
  output logic [31:0]     out_read_data,
  output logic            out_irq_pending,
  output logic            out_restart_request,
  output logic [2:0]      out_target_channel,
  output logic            out_kick_request
);
  import dmarf_pkg::*;

  localparam int NC = NUM_CHANNELS;

  logic [1:0]  op_r;
  logic [31:0] addr_r, wd_r;
  logic [1:0]  size_r;
  logic [2:0]  done_r;

  logic [2:0]  prio_r   [NC];
  logic [NC-1:0] men_r, ien_r, flag_r, flag_nxt;
  logic [3:0]  cpu_r;
  logic [6:0]  misc_r;
  logic        force_r, irqen_r;
  logic [23:0] badr_r [NC];
  logic [23:0] cadr_r [NC];
  logic [15:0] blen_r [NC];
  logic [15:0] clen_r [NC];
  logic [15:0] bcnt_r [NC];
  logic [31:0] ctl_r  [NC];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      addr_r <= in_address;
      size_r <= in_access_size;
      wd_r   <= in_write_data;
      done_r <= in_done_channel;
    end
  end

  // effective word address and lane-shifted write data
  logic [31:0] wa, wdata, rword, rshift, rd;
  logic [4:0]  sh;
  always_comb begin
    wa = addr_r;
    sh = 5'd0;
    wdata = wd_r;
    if (size_r == SZ_BYTE) begin
      wa = {addr_r[31:2], 2'b00};
      sh = {addr_r[1:0], 3'b000};
      wdata = {24'd0, wd_r[7:0]} << sh;
    end else if (size_r == SZ_HALF) begin
      wa = {addr_r[31:2], 2'b00};
      sh = {addr_r[1], 4'b0000};
      wdata = {16'd0, wd_r[15:0]} << sh;
    end
  end

  logic [2:0]  ch;
  logic        ch_live;
  logic [31:0] reg_a;
  assign ch      = wa[6:4];
  assign ch_live = 32'(ch) < NC;
  assign reg_a   = wa & DEC_MASK;

  logic mflag;
  assign mflag = force_r | (irqen_r & |(ien_r & flag_r));

  always_comb begin
    rword = 32'd0;
    if (wa == REG_DPCR) begin
      for (int c = 0; c < NC; c++) begin
        rword[4*c +: 3] = prio_r[c];
        rword[4*c+3]    = men_r[c];
      end
      rword[31:28] = cpu_r;
    end else if (wa == REG_DICR) begin
      rword[6:0] = misc_r;
      rword[15]  = force_r;
      rword[23]  = irqen_r;
      for (int c = 0; c < NC; c++) begin
        rword[16+c] = ien_r[c];
        rword[24+c] = flag_r[c];
      end
      rword[31] = mflag;
    end else if (wa >= REG_SPARE0 || wa[3:0] == 4'd12) begin
      rword = ALL_ONES;
    end else if (ch_live) begin
      if (reg_a == REG_MADR) rword = {8'd0, badr_r[ch]};
      else if (reg_a == REG_BCR) rword = {bcnt_r[ch], blen_r[ch]};
      else if (reg_a == REG_CHCR) rword = ctl_r[ch] & CHCR_BITS;
    end
  end

  always_comb begin
    rshift = rword >> sh;
    if (size_r == SZ_BYTE) rd = {24'd0, rshift[7:0]};
    else if (size_r == SZ_HALF) rd = {16'd0, rshift[15:0]};
    else rd = rshift;
  end

  logic        is_wr, is_chcr;
  logic [31:0] ctl_old, ctl_new, ctl_x;
  logic        re;
  assign is_wr   = cmd.execute && op_r == OP_WRITE;
  assign is_chcr = wa != REG_DPCR && wa != REG_DICR && wa != REG_SPARE0 &&
                   wa != REG_SPARE1 && ch_live && reg_a == REG_CHCR;
  always_comb begin
    ctl_old = ctl_r[ch];
    ctl_new = wdata & CHCR_BITS;
    if (32'(ch) == NC - 1) ctl_new = (ctl_new & LAST_KEEP) | LAST_FORCE;
    ctl_x = ctl_old ^ ctl_new;
    re = !ctl_old[24] || !ctl_new[24] || (ctl_x[10:9] != 2'd0) || (ctl_x[1:0] != 2'd0);
  end

  logic wr_other;
  assign wr_other = is_wr && wa != REG_DPCR && wa != REG_DICR &&
                    wa != REG_SPARE0 && wa != REG_SPARE1 && ch_live;

  always_comb begin
    flag_nxt = flag_r;
    if (is_wr && wa == REG_DICR) flag_nxt = flag_r & ~wdata[24 +: NC];
    if (cmd.execute && op_r == OP_DONE && 32'(done_r) < NC) flag_nxt[done_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      men_r <= '0; ien_r <= '0; flag_r <= '0;
      cpu_r <= '0; misc_r <= '0; force_r <= 1'b0; irqen_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        prio_r[c] <= '0; badr_r[c] <= '0; cadr_r[c] <= '0;
        blen_r[c] <= '0; clen_r[c] <= '0; bcnt_r[c] <= '0; ctl_r[c] <= '0;
      end
    end else begin
      flag_r <= flag_nxt;
      if (is_wr && wa == REG_DPCR) begin
        for (int c = 0; c < NC; c++) begin
          prio_r[c] <= wdata[4*c +: 3];
          men_r[c]  <= wdata[4*c+3];
        end
        cpu_r <= wdata[31:28];
      end
      if (is_wr && wa == REG_DICR) begin
        misc_r  <= wdata[6:0];
        force_r <= wdata[15];
        irqen_r <= wdata[23];
        ien_r   <= wdata[16 +: NC];
      end
      if (wr_other && reg_a == REG_MADR) begin
        badr_r[ch] <= wdata[23:0];
        cadr_r[ch] <= wdata[23:0];
      end
      if (wr_other && reg_a == REG_BCR) begin
        blen_r[ch] <= wdata[15:0];
        clen_r[ch] <= wdata[15:0];
        bcnt_r[ch] <= wdata[31:16];
      end
      if (wr_other && reg_a == REG_CHCR) begin
        ctl_r[ch] <= ctl_new;
        if (re) begin
          cadr_r[ch] <= badr_r[ch];
          clen_r[ch] <= blen_r[ch];
        end
      end
    end
  end

  // result register; master flag computed from the updated state
  logic [31:0] rd_r;
  logic        rst_req_r, kick_r;
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rd_r      <= (op_r == OP_READ) ? rd : 32'd0;
      rst_req_r <= is_wr && is_chcr && re;
      kick_r    <= is_wr && is_chcr;
    end
  end

  // current address/length registers; not brought out of this block
  logic unused_cur;
  always_comb begin
    unused_cur = 1'b0;
    for (int c = 0; c < NC; c++) unused_cur = unused_cur ^ (^cadr_r[c]) ^ (^clen_r[c]);
  end

  assign out_read_data       = rd_r;
  assign out_irq_pending     = mflag | (unused_cur & 1'b0);
  assign out_restart_request = rst_req_r;
  assign out_target_channel  = addr_r[6:4];
  assign out_kick_request    = kick_r;

  a_no_kick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && !(is_wr && is_chcr) |=> !out_kick_request && !out_restart_request)
    else $error("kick or restart without control write");
  a_kick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && is_wr && is_chcr |=> out_kick_request)
    else $error("control write without kick");
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && op_r != OP_READ |=> out_read_data == 32'd0)
    else $error("read data on non-read transfer");
endmodule

/* src/dma_channel_register_file_top.sv */
// ----------------------------------------------------------------------------
// DMA channel register file top level
// Register window of a seven-channel DMA controller, one bus access a transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: operation (read, write, completion event), address,
//   access size, write data and done channel. A transfer is taken when
//   in_valid is high and in_stall is low.
//   Result channel out_*: read data, master interrupt flag, restart and kick
//   pulses and the decoded channel index, one result per input transfer.
//   Sequence: capture, then execute, then the result is shown with out_valid.
//   Throughput is set by the capture/execute sequence of the controller;
//   a new input is taken while the result is being handed off.
//   Reset (rst_n low, synchronous) clears the register state to zero and
//   returns the controller to idle.
//   While out_stall is high with out_valid, the result holds and in_stall stays high.
// ----------------------------------------------------------------------------
module dma_channel_register_file_top #(
  parameter int NUM_CHANNELS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_address,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_done_channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_pending,
  output logic        out_restart_request,
  output logic [2:0]  out_target_channel,
  output logic        out_kick_request
);
  import dmarf_pkg::*;

  cmd_t cmd;

  dmarf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  dmarf_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_operation(in_operation), .in_address(in_address),
    .in_access_size(in_access_size), .in_write_data(in_write_data),
    .in_done_channel(in_done_channel),
    .out_read_data(out_read_data), .out_irq_pending(out_irq_pending),
    .out_restart_request(out_restart_request),
    .out_target_channel(out_target_channel), .out_kick_request(out_kick_request)
  );

endmodule
